@@ sv/led_pkg.sv @@
`default_nettype none

package led_pkg;

  localparam int PIX_W          = 8;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 13;
  localparam int THR_REG_W    = 8;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd256;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd256;
  localparam logic [THR_REG_W-1:0]    THR_RESET    = 8'd125;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_DARK_THRESHOLD
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

`default_nettype wire

@@ sv/led_pix_if.sv @@
`default_nettype none

interface led_pix_if;
  import led_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   padding;

  modport source (output valid, output pixel, output padding, input ready);
  modport sink   (input valid, input pixel, input padding, output ready);
endinterface

`default_nettype wire

@@ sv/led_res_if.sv @@
`default_nettype none

interface led_res_if;
  import led_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t edge_pixel;
  logic   last_of_frame;

  modport source (output valid, output edge_pixel, output last_of_frame, input ready);
  modport sink   (input valid, input edge_pixel, input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ sv/led_ram.sv @@
`default_nettype none

module led_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/laplacian_edge_detect_top.sv @@
`default_nettype none

// 4-neighbour 3x3 Laplacian edge detector for 8-bit grey frames.
//
// pixels  : one beat per pixel in row-major order. A beat with padding set
//           is filler; after the last row send image_width padding beats
//           to drain that row. Padding inside the frame and pixels inside
//           the drain row are taken and dropped.
// results : one beat per pixel of rows 0..height-1, produced while the row
//           below arrives; last_of_frame marks the final pixel of a frame.
// cfg     : plain write port (image_width, image_height, dark_threshold).
//           Any valid write restarts the frame; the line stores keep data.
//
// Throughput is one pixel per clock while ready is high: the line store is
// a single RAM with one read and one write port, read one column ahead of the pixel.
// A result passes through the stage-1 tap registers and then the output
// queue registers before results.valid rises for it.
// The output queue holds three beats; when the receiver stalls, pixels
// keep flowing until queue plus stage 1 hold three beats, then ready drops.
// After reset the line RAM is cleared, one entry per cycle, over all
// MAX_WIDTH entries, and then column zero is fetched; after a configuration
// write column zero is fetched again. Ready stays low meanwhile.
module laplacian_edge_detect_top #(
  parameter int MAX_WIDTH  = led_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = led_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  led_pix_if.sink                             pixels,
  led_res_if.source                           results,
  input  wire logic                           cfg_write,
  input  wire logic [led_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [led_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import led_pkg::*;

  // column index, effective width (holds MAX_WIDTH), row counter (holds height)
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int CMPW = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPH = (HW > HEIGHT_REG_W) ? HW : HEIGHT_REG_W;
  localparam int SW   = PIX_W + 2;           // four-pixel sum
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [THR_REG_W-1:0]    thr_reg;
  logic                    cfg_hit;

  always_comb begin
    unique case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_DARK_THRESHOLD: cfg_hit = cfg_write;
      default:                                               cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      thr_reg    <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    width_reg  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:   height_reg <= cfg_data[HEIGHT_REG_W-1:0];
        REG_DARK_THRESHOLD: thr_reg    <= cfg_data[THR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to the supported range
  logic [CMPW-1:0] width_ext;
  logic [CMPH-1:0] height_ext;
  logic [EW-1:0]   eff_w;
  logic [HW-1:0]   eff_h;

  assign width_ext  = CMPW'(width_reg);
  assign height_ext = CMPH'(height_reg);

  always_comb begin
    if (width_ext < CMPW'(MIN_WIDTH)) begin
      eff_w = EW'(MIN_WIDTH);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_ext);
    end
    if (height_ext < CMPH'(MIN_HEIGHT)) begin
      eff_h = HW'(MIN_HEIGHT);
    end else if (height_ext > CMPH'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Line RAM: each entry is {upper row, middle row} of one column
  // ---------------------------------------------------------------------
  logic                 ram_we;
  logic [CW-1:0]        ram_waddr;
  logic [2*PIX_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [CW-1:0]        ram_raddr;
  logic [2*PIX_W-1:0]   ram_rdata;
  pixel_t               rd_up;
  pixel_t               rd_mid;

  led_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_up  = ram_rdata[2*PIX_W-1:PIX_W];
  assign rd_mid = ram_rdata[PIX_W-1:0];

  // ---------------------------------------------------------------------
  // Position, clearing pass and prefetch state
  // ---------------------------------------------------------------------
  logic [CW-1:0] col;
  logic [HW-1:0] row;
  logic          clearing;
  logic [CW-1:0] clr_addr;
  logic          pf_valid;      // RAM read data holds the entry of col
  pixel_t        prev_centre;   // centre tap of the previous column

  logic [EW-1:0] col_plus;
  logic          col_last;
  logic          drain;
  logic          take;
  logic          work;

  // stage 1: taps captured at accept, right tap arrives from the RAM
  logic   s1_valid;
  pixel_t s1_above;
  pixel_t s1_below;
  pixel_t s1_left;
  pixel_t s1_centre;
  logic   s1_right_zero;
  logic   s1_last;

  // output queue
  pixel_t            oq_edge [OQ_DEPTH];
  logic              oq_last [OQ_DEPTH];
  logic [OQ_PW-1:0]  oq_wr_ptr;
  logic [OQ_PW-1:0]  oq_rd_ptr;
  logic [OQ_CW-1:0]  oq_count;
  logic              oq_pop;
  logic [OQ_CW:0]    oq_committed;

  assign col_plus = {1'b0, col} + EW'(1);
  assign col_last = (col_plus == eff_w);
  assign drain    = (row >= eff_h);

  // space for this beat plus the one in stage 1
  assign oq_committed = (OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(s1_valid);
  assign pixels.ready = pf_valid && !clearing && (oq_committed < (OQ_CW + 1)'(OQ_DEPTH));

  assign take = pixels.valid && pixels.ready;
  // padding inside the frame and pixels inside the drain row are dropped
  assign work = take && (drain == pixels.padding);

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = '0;
    end else begin
      // shift the column down: middle becomes upper, new pixel becomes middle
      ram_we    = work && !drain;
      ram_waddr = col;
      ram_wdata = {rd_mid, pixels.pixel};
      // read one column ahead; wrap to column zero for the next row
      ram_re    = work || !pf_valid;
      if (work && !col_last) begin
        ram_raddr = col_plus[CW-1:0];
      end else begin
        ram_raddr = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      pf_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_hit) begin
        // restart the frame; refetch column zero
        pf_valid <= 1'b0;
        col      <= '0;
        row      <= '0;
      end else begin
        if (!clearing && !pf_valid) begin
          pf_valid <= 1'b1;
        end
        if (work) begin
          if (col_last) begin
            col <= '0;
            row <= drain ? '0 : row + HW'(1);
          end else begin
            col <= col_plus[CW-1:0];
          end
        end
      end
    end
  end

  // capture taps of the accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= work && (row != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      prev_centre   <= rd_mid;
      s1_above      <= (row >= HW'(2)) ? rd_up : '0;
      s1_below      <= drain ? '0 : pixels.pixel;
      s1_left       <= (col == '0) ? '0 : prev_centre;
      s1_centre     <= rd_mid;
      s1_right_zero <= col_last;
      s1_last       <= drain && col_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 arithmetic: |up + down + left + right - 4*centre|,
  // saturate, invert, threshold
  // ---------------------------------------------------------------------
  pixel_t      s1_right;
  logic [SW-1:0] pos_sum;
  logic [SW-1:0] neg_sum;
  logic [SW-1:0] mag;
  pixel_t      sat;
  pixel_t      inv;
  pixel_t      edge_val;

  always_comb begin
    s1_right = s1_right_zero ? '0 : rd_mid;
    pos_sum  = SW'(s1_above) + SW'(s1_below) + SW'(s1_left) + SW'(s1_right);
    neg_sum  = {s1_centre, 2'b00};
    mag      = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
    sat      = (mag > SW'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : mag[PIX_W-1:0];
    inv      = ~sat;
    edge_val = (inv < thr_reg) ? '0 : inv;
  end

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  assign oq_pop                = results.valid && results.ready;
  assign results.valid         = (oq_count != '0);
  assign results.edge_pixel    = oq_edge[oq_rd_ptr];
  assign results.last_of_frame = oq_last[oq_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= '0;
      oq_rd_ptr <= '0;
      oq_count  <= '0;
    end else begin
      if (s1_valid) begin
        oq_wr_ptr <= (oq_wr_ptr == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_wr_ptr + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rd_ptr <= (oq_rd_ptr == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_rd_ptr + OQ_PW'(1);
      end
      oq_count <= oq_count + OQ_CW'(s1_valid) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq_edge[oq_wr_ptr] <= edge_val;
      oq_last[oq_wr_ptr] <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (oq_count != OQ_CW'(OQ_DEPTH) || oq_pop))
    else $error("output queue overflow");

  a_ram_no_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("line RAM read and write hit the same column");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (work && drain && col_last && !cfg_hit) |=> (col == '0 && row == '0))
    else $error("counters not restarted after the drain row");

  a_prefetch_before_use: assert property (@(posedge clk) disable iff (rst)
    take |-> $past(!clearing))
    else $error("beat accepted right after the clearing pass");

endmodule

`default_nettype wire
